/* hw/rtl/lst_pkg.sv */
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and command codes for the lock slot table.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int ID_W  = 64;
    localparam int CMD_W = 3;

    // request commands
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd4;

    // bank select
    localparam logic BANK_SPIN  = 1'b0;
    localparam logic BANK_MUTEX = 1'b1;

    // request token that walks down the slot chain
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bank;
        logic [ID_W-1:0]  lock_id;
        logic [ID_W-1:0]  owner_id;
        logic [ID_W-1:0]  new_id;
        logic             done;
        logic             ok;
    } t_tok;

endpackage

/* hw/rtl/lst_req_if.sv */
// ----------------------------------------------------------------------------
// lst_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface lst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        bank;
    logic [63:0] lock_id;
    logic [63:0] owner_id;

    modport source (output valid, cmd, bank, lock_id, owner_id, input ready);
    modport sink   (input valid, cmd, bank, lock_id, owner_id, output ready);
endinterface

/* hw/rtl/lst_rsp_if.sv */
// ----------------------------------------------------------------------------
// lst_rsp_if
// Response channel: valid/ready handshake with status and new id.
// ----------------------------------------------------------------------------
interface lst_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [63:0] new_id;

    modport source (output valid, status, new_id, input ready);
    modport sink   (input valid, status, new_id, output ready);
endinterface

/* hw/rtl/lst_cell.sv */
// ----------------------------------------------------------------------------
// lst_cell
// One slot of both banks; acts on the passing request token and forwards it.
// ----------------------------------------------------------------------------
module lst_cell
    import lst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_tok i_tok,
    output logic o_vld,
    output t_tok o_tok
);

    // slot state, index 0 spin bank, index 1 mutex bank
    logic [1:0]      r_used, n_used;
    logic [1:0]      r_held, n_held;
    logic [ID_W-1:0] r_id [2];
    logic [ID_W-1:0] n_id [2];
    logic [ID_W-1:0] r_owner, n_owner;

    logic r_vld;
    t_tok r_tok, n_tok;
    logic w_hit;

    assign w_hit = r_used[i_tok.bank] && (r_id[i_tok.bank] == i_tok.lock_id);

    // slot update and token hand-off
    always_comb begin
        n_used  = r_used;
        n_held  = r_held;
        n_id[0] = r_id[0];
        n_id[1] = r_id[1];
        n_owner = r_owner;
        n_tok   = i_tok;
        if (i_vld) begin
            if (i_tok.cmd == CMD_INIT) begin
                n_used = '0;
                n_held = '0;
            end else if (!i_tok.done) begin
                case (i_tok.cmd)
                    CMD_CREATE: begin
                        if (!r_used[i_tok.bank]) begin
                            n_used[i_tok.bank] = 1'b1;
                            n_held[i_tok.bank] = 1'b0;
                            n_id[i_tok.bank]   = i_tok.new_id;
                            n_tok.done         = 1'b1;
                            n_tok.ok           = 1'b1;
                        end
                    end
                    CMD_LOCK: begin
                        if (w_hit) begin
                            n_tok.done = 1'b1;
                            if (!r_held[i_tok.bank] &&
                                (i_tok.bank == BANK_SPIN || i_tok.owner_id != '0)) begin
                                n_held[i_tok.bank] = 1'b1;
                                if (i_tok.bank == BANK_MUTEX) begin
                                    n_owner = i_tok.owner_id;
                                end
                                n_tok.ok = 1'b1;
                            end
                        end
                    end
                    CMD_UNLOCK: begin
                        if (w_hit) begin
                            n_tok.done = 1'b1;
                            if (r_held[i_tok.bank] &&
                                (i_tok.bank == BANK_SPIN || r_owner == i_tok.owner_id)) begin
                                n_held[i_tok.bank] = 1'b0;
                                n_tok.ok           = 1'b1;
                            end
                        end
                    end
                    CMD_DESTROY: begin
                        if (w_hit) begin
                            n_used[i_tok.bank] = 1'b0;
                            n_held[i_tok.bank] = 1'b0;
                            n_tok.done         = 1'b1;
                            n_tok.ok           = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_held <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_used <= n_used;
            r_held <= n_held;
            r_vld  <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_id[0] <= n_id[0];
        r_id[1] <= n_id[1];
        r_owner <= n_owner;
        r_tok   <= n_tok;
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

/* hw/rtl/lock_slot_table.sv */
// ----------------------------------------------------------------------------
// lock_slot_table
// Lock table with a spinlock bank and an owner-tracked mutex bank.
// ----------------------------------------------------------------------------
// Each request walks a chain of SLOT_COUNT slot cells, one cell per cycle,
// from slot 0 upward, so the first free or first matching slot acts on it.
// One request is in the chain at a time: its token passes the cell chain, then
// the tail register and the output register; the next request is accepted
// once the token has left the tail register. A finished response waits in the
// output register while the next request already runs. Init clears both banks
// as it passes the cells.
module lock_slot_table
    import lst_pkg::*;
#(
    parameter int SLOT_COUNT = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    lst_req_if.sink   i_req,
    lst_rsp_if.source o_rsp
);

    logic            w_vld [SLOT_COUNT+1];
    t_tok            w_tok [SLOT_COUNT+1];
    logic [SLOT_COUNT:0] w_vld_vec;

    logic            r_init, r_busy, r_tail_v, r_out_v;
    logic [ID_W-1:0] r_cnt;
    t_tok            r_tail;
    logic            r_out_status;
    logic [ID_W-1:0] r_out_new_id;

    logic            w_acc;
    logic            w_tail_move;
    logic            w_cmd_known;
    t_tok            w_entry;

    assign w_acc       = i_req.valid && i_req.ready;
    assign i_req.ready = !r_busy && !r_tail_v;
    assign w_tail_move = r_tail_v && (!r_out_v || o_rsp.ready);
    assign w_cmd_known = i_req.cmd inside {CMD_INIT, CMD_CREATE, CMD_LOCK,
                                           CMD_UNLOCK, CMD_DESTROY};

    // token built at entry; commands settled without the slots are marked done
    always_comb begin
        w_entry.cmd      = i_req.cmd;
        w_entry.bank     = i_req.bank;
        w_entry.lock_id  = i_req.lock_id;
        w_entry.owner_id = i_req.owner_id;
        w_entry.new_id   = r_cnt + 64'd1;
        w_entry.done     = 1'b0;
        w_entry.ok       = 1'b0;
        if (!w_cmd_known) begin
            w_entry.done = 1'b1;
        end else if (i_req.cmd == CMD_INIT) begin
            w_entry.done = 1'b1;
            w_entry.ok   = 1'b1;
        end else if (i_req.cmd == CMD_CREATE && !r_init) begin
            w_entry.done = 1'b1;
        end
    end

    assign w_vld[0] = w_acc;
    assign w_tok[0] = w_entry;

    // slot chain
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        lst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_tok   (w_tok[g]),
            .o_vld   (w_vld[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    for (genvar g = 0; g <= SLOT_COUNT; g++) begin : g_vec
        assign w_vld_vec[g] = w_vld[g];
    end

    // control: busy flag, tail and output valid, init flag, id counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= 1'b0;
            r_busy   <= 1'b0;
            r_tail_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (w_acc) begin
                r_busy <= 1'b1;
                if (i_req.cmd == CMD_INIT) begin
                    r_init <= 1'b1;
                    r_cnt  <= '0;
                end
            end
            if (w_vld[SLOT_COUNT]) begin
                r_busy   <= 1'b0;
                r_tail_v <= 1'b1;
                if (w_tok[SLOT_COUNT].cmd == CMD_CREATE && w_tok[SLOT_COUNT].ok) begin
                    r_cnt <= w_tok[SLOT_COUNT].new_id;
                end
            end else if (w_tail_move) begin
                r_tail_v <= 1'b0;
            end
            if (w_tail_move) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload: tail capture and response register
    always_ff @(posedge i_clk) begin
        if (w_vld[SLOT_COUNT]) begin
            r_tail <= w_tok[SLOT_COUNT];
        end
        if (w_tail_move) begin
            r_out_status <= !r_tail.ok;
            r_out_new_id <= (r_tail.ok && r_tail.cmd == CMD_CREATE) ? r_tail.new_id : '0;
        end
    end

    assign o_rsp.valid  = r_out_v;
    assign o_rsp.status = r_out_status;
    assign o_rsp.new_id = r_out_new_id;

    // at most one request token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld_vec) <= 1)
        else $error("more than one token in slot chain");

    // an accepted request keeps the block busy next cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_busy)
        else $error("accepted request did not mark busy");

    // a token leaving the chain always finds the tail free
    a_tail_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[SLOT_COUNT] |-> !r_tail_v)
        else $error("tail overwritten");

    // a failed response never carries an id
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_status) |-> (r_out_new_id == '0))
        else $error("failed response with nonzero id");

endmodule
